/* src/cpo_pkg.sv */
// Shared types for the closest point on polygon outline block.
package cpo_pkg;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIFF,
      OP_MUL,
      OP_SUM,
      OP_NUM,
      OP_DIVLD,
      OP_DIVSTEP,
      OP_CAND,
      OP_ERR,
      OP_SQ,
      OP_CMP,
      OP_EMIT
   } op_type;

   typedef enum logic {
      EDGE_PREV,
      EDGE_CLOSE
   } edge_type;

   typedef struct packed {
      op_type   op;
      logic     first;
      edge_type edge_sel;
   } cmd_type;

   typedef struct packed {
      logic proj;
      logic out_free;
   } sts_type;

endpackage

/* src/cpo_datapath.sv */
// Datapath: vertex registers, edge projection arithmetic, divider lanes, best candidate.
module cpo_datapath #(
   parameter int COORD_WIDTH = 15,
   parameter int FRAC_BITS   = 8,
   parameter int IN_W        = ((4 * COORD_WIDTH + 7) / 8) * 8,
   parameter int OUT_W       = ((2 * (COORD_WIDTH + FRAC_BITS) + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  cpo_pkg::cmd_type   cmd,
   output cpo_pkg::sts_type   sts,
   input  logic [IN_W-1:0]    req_tdata,
   output logic [OUT_W-1:0]   rsp_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready
);

   localparam int W    = COORD_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int DW   = W + 1;
   localparam int PW   = 2 * DW;
   localparam int DOTW = 2 * W + 2;
   localparam int LENW = 2 * W + 1;
   localparam int MW   = LENW + W;
   localparam int QB   = W + F;
   localparam int RW   = LENW + 2;
   localparam int NW   = LENW + W + F + 2;
   localparam int OW   = W + F;
   localparam int EW   = OW + 1;
   localparam int SQW  = 2 * EW;
   localparam int DSTW = SQW + 1;

   logic signed [W-1:0]    cur_x_ff, cur_y_ff, prior_x_ff, prior_y_ff;
   logic signed [W-1:0]    start_x_ff, start_y_ff, center_x_ff, center_y_ff;
   logic signed [DW-1:0]   dx_ff, dy_ff, wx_ff, wy_ff;
   logic signed [PW-1:0]   pdx_ff, pdy_ff, sqx_ff, sqy_ff;
   logic signed [DOTW-1:0] dot_ff;
   logic [LENW-1:0]        len_ff;
   logic [MW-1:0]          num_x_ff, num_y_ff;
   logic [RW-1:0]          rem_x_ff, rem_y_ff;
   logic [QB-1:0]          nq_x_ff, nq_y_ff;
   logic signed [OW-1:0]   px_ff, py_ff;
   logic signed [EW-1:0]   ex_ff, ey_ff;
   logic [SQW-1:0]         esx_ff, esy_ff;
   logic                   best_valid_ff;
   logic [DSTW-1:0]        best_dist_ff;
   logic [OW-1:0]          best_x_ff, best_y_ff;
   logic                   out_valid_ff;
   logic [OW-1:0]          out_x_ff, out_y_ff;

   logic signed [W-1:0]    ax, ay, bx, by;
   logic signed [W-1:0]    in_vx, in_vy, in_qx, in_qy;
   logic                   clamp_a, take_b;
   logic [DW-1:0]          mag_x, mag_y;
   logic [NW-1:0]          n_x, n_y;
   logic [RW-1:0]          den;
   logic [RW-1:0]          rr_x, rr_y;
   logic signed [EW-1:0]   ax_sh, ay_sh, bx_sh, by_sh, cx_sh, cy_sh;
   logic signed [EW-1:0]   off_x, off_y, cand_x, cand_y;
   logic [DSTW-1:0]        dist_sq;

   assign in_vx = req_tdata[W-1:0];
   assign in_vy = req_tdata[2*W-1:W];
   assign in_qx = req_tdata[3*W-1:2*W];
   assign in_qy = req_tdata[4*W-1:3*W];

   // Edge endpoints: previous vertex to current, or current back to the first.
   assign ax = (cmd.edge_sel == cpo_pkg::EDGE_PREV) ? prior_x_ff : cur_x_ff;
   assign ay = (cmd.edge_sel == cpo_pkg::EDGE_PREV) ? prior_y_ff : cur_y_ff;
   assign bx = (cmd.edge_sel == cpo_pkg::EDGE_PREV) ? cur_x_ff : start_x_ff;
   assign by = (cmd.edge_sel == cpo_pkg::EDGE_PREV) ? cur_y_ff : start_y_ff;

   assign clamp_a  = (len_ff == '0) || dot_ff[DOTW-1];
   assign take_b   = !clamp_a && (dot_ff[LENW-1:0] >= len_ff);
   assign sts.proj = !clamp_a && !take_b;
   assign sts.out_free = !out_valid_ff || rsp_tready;

   assign mag_x = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
   assign mag_y = dy_ff[DW-1] ? DW'(-dy_ff) : DW'(dy_ff);

   // Rounded quotient: (num * 2^(F+1) + len) / (2 * len)
   assign n_x = NW'({num_x_ff, {(F + 1){1'b0}}}) + NW'(len_ff);
   assign n_y = NW'({num_y_ff, {(F + 1){1'b0}}}) + NW'(len_ff);
   assign den = RW'({len_ff, 1'b0});
   assign rr_x = {rem_x_ff[RW-2:0], nq_x_ff[QB-1]};
   assign rr_y = {rem_y_ff[RW-2:0], nq_y_ff[QB-1]};

   assign ax_sh = $signed({ax[W-1], ax, {F{1'b0}}});
   assign ay_sh = $signed({ay[W-1], ay, {F{1'b0}}});
   assign bx_sh = $signed({bx[W-1], bx, {F{1'b0}}});
   assign by_sh = $signed({by[W-1], by, {F{1'b0}}});
   assign cx_sh = $signed({center_x_ff[W-1], center_x_ff, {F{1'b0}}});
   assign cy_sh = $signed({center_y_ff[W-1], center_y_ff, {F{1'b0}}});
   assign off_x = dx_ff[DW-1] ? -$signed({1'b0, nq_x_ff}) : $signed({1'b0, nq_x_ff});
   assign off_y = dy_ff[DW-1] ? -$signed({1'b0, nq_y_ff}) : $signed({1'b0, nq_y_ff});

   always_comb begin
      if (clamp_a) begin
         cand_x = ax_sh;
         cand_y = ay_sh;
      end else if (take_b) begin
         cand_x = bx_sh;
         cand_y = by_sh;
      end else begin
         cand_x = ax_sh + off_x;
         cand_y = ay_sh + off_y;
      end
   end

   assign dist_sq = DSTW'(esx_ff) + DSTW'(esy_ff);

   always_ff @(posedge clock) begin
      case (cmd.op)
         cpo_pkg::OP_LOAD: begin
            prior_x_ff <= cur_x_ff;
            prior_y_ff <= cur_y_ff;
            cur_x_ff   <= in_vx;
            cur_y_ff   <= in_vy;
            if (cmd.first) begin
               start_x_ff  <= in_vx;
               start_y_ff  <= in_vy;
               center_x_ff <= in_qx;
               center_y_ff <= in_qy;
            end
         end
         cpo_pkg::OP_DIFF: begin
            dx_ff <= DW'(bx) - DW'(ax);
            dy_ff <= DW'(by) - DW'(ay);
            wx_ff <= DW'(center_x_ff) - DW'(ax);
            wy_ff <= DW'(center_y_ff) - DW'(ay);
         end
         cpo_pkg::OP_MUL: begin
            pdx_ff <= dx_ff * wx_ff;
            pdy_ff <= dy_ff * wy_ff;
            sqx_ff <= dx_ff * dx_ff;
            sqy_ff <= dy_ff * dy_ff;
         end
         cpo_pkg::OP_SUM: begin
            dot_ff <= DOTW'(pdx_ff + pdy_ff);
            len_ff <= LENW'(sqx_ff + sqy_ff);
         end
         cpo_pkg::OP_NUM: begin
            num_x_ff <= MW'(dot_ff[LENW-1:0]) * MW'(mag_x[W-1:0]);
            num_y_ff <= MW'(dot_ff[LENW-1:0]) * MW'(mag_y[W-1:0]);
         end
         cpo_pkg::OP_DIVLD: begin
            rem_x_ff <= n_x[NW-1:QB];
            rem_y_ff <= n_y[NW-1:QB];
            nq_x_ff  <= n_x[QB-1:0];
            nq_y_ff  <= n_y[QB-1:0];
         end
         cpo_pkg::OP_DIVSTEP: begin
            // shift one numerator bit into the remainder, shift in one quotient bit
            if (rr_x >= den) begin
               rem_x_ff <= rr_x - den;
               nq_x_ff  <= {nq_x_ff[QB-2:0], 1'b1};
            end else begin
               rem_x_ff <= rr_x;
               nq_x_ff  <= {nq_x_ff[QB-2:0], 1'b0};
            end
            if (rr_y >= den) begin
               rem_y_ff <= rr_y - den;
               nq_y_ff  <= {nq_y_ff[QB-2:0], 1'b1};
            end else begin
               rem_y_ff <= rr_y;
               nq_y_ff  <= {nq_y_ff[QB-2:0], 1'b0};
            end
         end
         cpo_pkg::OP_CAND: begin
            px_ff <= cand_x[OW-1:0];
            py_ff <= cand_y[OW-1:0];
         end
         cpo_pkg::OP_ERR: begin
            ex_ff <= EW'(px_ff) - cx_sh;
            ey_ff <= EW'(py_ff) - cy_sh;
         end
         cpo_pkg::OP_SQ: begin
            esx_ff <= SQW'(ex_ff * ex_ff);
            esy_ff <= SQW'(ey_ff * ey_ff);
         end
         cpo_pkg::OP_CMP: begin
            if (!best_valid_ff || (dist_sq < best_dist_ff)) begin
               best_dist_ff <= dist_sq;
               best_x_ff    <= px_ff;
               best_y_ff    <= py_ff;
            end
         end
         cpo_pkg::OP_EMIT: begin
            out_x_ff <= best_x_ff;
            out_y_ff <= best_y_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.op == cpo_pkg::OP_LOAD && cmd.first) begin
            best_valid_ff <= 1'b0;
         end else if (cmd.op == cpo_pkg::OP_CMP) begin
            best_valid_ff <= 1'b1;
         end
         if (cmd.op == cpo_pkg::OP_EMIT) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_W'({out_y_ff, out_x_ff});

`ifndef SYNTHESIS
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.op == cpo_pkg::OP_DIVSTEP) |-> (rem_x_ff < den) && (rem_y_ff < den))
      else $error("divider remainder not below divisor");
   a_best_after_cmp: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cpo_pkg::OP_CMP) |=> best_valid_ff)
      else $error("best candidate not marked after compare");
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.op == cpo_pkg::OP_EMIT))
      else $error("result word raised without emit");
   a_emit_has_best: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cpo_pkg::OP_EMIT) |-> best_valid_ff)
      else $error("emit without a candidate");
`endif

endmodule

/* src/cpo_ctrl.sv */
// Controller: sequences loads, edge evaluation steps, division and result emit.
module cpo_ctrl #(
   parameter int COORD_WIDTH = 15,
   parameter int FRAC_BITS   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tlast,
   output logic             req_tready,
   output cpo_pkg::cmd_type cmd,
   input  cpo_pkg::sts_type sts
);

   localparam int QB = COORD_WIDTH + FRAC_BITS;
   localparam int CW = $clog2(QB);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_SUM,
      ST_NUM,
      ST_DIVLD,
      ST_DIV,
      ST_CAND,
      ST_ERR,
      ST_SQ,
      ST_CMP,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [CW-1:0]     cnt_ff;
   logic              in_set_ff;
   logic              last_ff;
   cpo_pkg::edge_type edge_ff;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.first    = !in_set_ff;
      cmd.edge_sel = edge_ff;
      case (state_ff)
         ST_IDLE:  cmd.op = req_tvalid ? cpo_pkg::OP_LOAD : cpo_pkg::OP_NONE;
         ST_DIFF:  cmd.op = cpo_pkg::OP_DIFF;
         ST_MUL:   cmd.op = cpo_pkg::OP_MUL;
         ST_SUM:   cmd.op = cpo_pkg::OP_SUM;
         ST_NUM:   cmd.op = cpo_pkg::OP_NUM;
         ST_DIVLD: cmd.op = cpo_pkg::OP_DIVLD;
         ST_DIV:   cmd.op = cpo_pkg::OP_DIVSTEP;
         ST_CAND:  cmd.op = cpo_pkg::OP_CAND;
         ST_ERR:   cmd.op = cpo_pkg::OP_ERR;
         ST_SQ:    cmd.op = cpo_pkg::OP_SQ;
         ST_CMP:   cmd.op = cpo_pkg::OP_CMP;
         ST_EMIT:  cmd.op = sts.out_free ? cpo_pkg::OP_EMIT : cpo_pkg::OP_NONE;
         default:  cmd.op = cpo_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         in_set_ff <= 1'b0;
         last_ff   <= 1'b0;
         edge_ff   <= cpo_pkg::EDGE_PREV;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  last_ff <= req_tlast;
                  if (!in_set_ff) begin
                     in_set_ff <= 1'b1;
                     // a lone vertex still closes on itself
                     if (req_tlast) begin
                        edge_ff  <= cpo_pkg::EDGE_CLOSE;
                        state_ff <= ST_DIFF;
                     end
                  end else begin
                     edge_ff  <= cpo_pkg::EDGE_PREV;
                     state_ff <= ST_DIFF;
                  end
               end
            end
            ST_DIFF:  state_ff <= ST_MUL;
            ST_MUL:   state_ff <= ST_SUM;
            ST_SUM:   state_ff <= ST_NUM;
            ST_NUM:   state_ff <= sts.proj ? ST_DIVLD : ST_CAND;
            ST_DIVLD: begin
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (cnt_ff == CW'(QB - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_CAND;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_CAND:  state_ff <= ST_ERR;
            ST_ERR:   state_ff <= ST_SQ;
            ST_SQ:    state_ff <= ST_CMP;
            ST_CMP: begin
               if (last_ff && edge_ff == cpo_pkg::EDGE_PREV) begin
                  edge_ff  <= cpo_pkg::EDGE_CLOSE;
                  state_ff <= ST_DIFF;
               end else if (last_ff) begin
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_EMIT: begin
               // hold until the output register is free
               if (sts.out_free) begin
                  in_set_ff <= 1'b0;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= CW'(QB - 1)))
      else $error("divide step count out of range");
   a_open_set_edge: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && in_set_ff) |=> (state_ff == ST_DIFF))
      else $error("vertex in open set did not start an edge");
   a_emit_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && sts.out_free) |=> !in_set_ff && state_ff == ST_IDLE)
      else $error("emit did not close the set");
`endif

endmodule

/* src/closest_point_on_polygon_outline_top.sv */
// Top level of the closest point on polygon outline block.
//
//   channel  direction  tdata (low bit first)                    tuser/tlast
//   req_     in         vertex_x, vertex_y, query_x, query_y     tlast = last_vertex
//   rsp_     out        closest_x, closest_y (signed Q.FRAC)     none
//
// An item is loaded, then each edge runs the difference, multiply, sum,
// numerator, candidate, error, square and compare states; a projected edge
// adds a divider load and the bit-serial divider that runs both coordinates
// in parallel. A last vertex also evaluates the closing edge, then loads the result.
// Synchronous active-high reset; a set open at reset is dropped.
// A stalled result sits in the output register while the next vertex is taken.
module closest_point_on_polygon_outline_top #(
   parameter int COORD_WIDTH = 15,
   parameter int FRAC_BITS   = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // vertex_x, vertex_y, query_x, query_y, zero pad
   input  logic [((4 * COORD_WIDTH + 7) / 8) * 8 - 1:0]               req_tdata,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // closest_x, closest_y, zero pad
   output logic [((2 * (COORD_WIDTH + FRAC_BITS) + 7) / 8) * 8 - 1:0] rsp_tdata
);

   cpo_pkg::cmd_type cmd;
   cpo_pkg::sts_type sts;

   cpo_ctrl #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   cpo_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

endmodule
